// ----- rtl/self_organizing_list_transpose_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the self-organising list
// Clock is clk, synchronous active-low reset is rst_n in every user.
// ---------------------------------------------------------------------------
`ifndef SELF_ORGANIZING_LIST_TRANSPOSE_DEFINES_SVH
`define SELF_ORGANIZING_LIST_TRANSPOSE_DEFINES_SVH

// Same-cycle implication.
`define SOLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SOLT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/solt_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// solt_pkg
// Shared constants, codes, types and ring helper for the self-organising list.
// ---------------------------------------------------------------------------
package solt_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 11;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 10;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_APPEND_END   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND_FRONT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEARCH       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_FRONT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ_BACK    = 3'd5;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // register word index
  localparam logic REG_TRANSPOSE_EN = 1'b0;

  localparam logic [ADDR_W:0]   SUM_CAP  = (ADDR_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [ADDR_W-1:0] SLOT_TOP = ADDR_W'(CAPACITY - 1);

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] read_value;
    logic [CNT_W-1:0]          length;
  } res_t;

  // (a + b) modulo CAPACITY, both operands below CAPACITY
  function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= SUM_CAP) begin
      sum = sum - SUM_CAP;
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/solt_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// solt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module solt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- rtl/solt_engine.sv -----
`timescale 1ns / 1ps
`include "self_organizing_list_transpose_defines.svh"
// ---------------------------------------------------------------------------
// solt_engine
// Command sequencer around the ring store: appends, delete, reads, scan+swap.
// ---------------------------------------------------------------------------
module solt_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  solt_pkg::cmd_t cmd,
  input  logic          tp_en,
  output logic          res_valid,
  input  logic          res_ready,
  output solt_pkg::res_t res
);
  import solt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_SWAP, S_RDWAIT, S_DONE
  } state_t;

  state_t                    state_r;
  cmd_t                      cmd_r;
  logic [ADDR_W-1:0]         front_r;
  logic [CNT_W-1:0]          count_r;
  logic [ADDR_W-1:0]         cmp_r;
  logic signed [VALUE_W-1:0] prev_r;
  logic [STATUS_W-1:0]       status_r;
  logic [INDEX_W-1:0]        index_r;
  logic signed [VALUE_W-1:0] rdval_r;

  logic                      we, re;
  logic [ADDR_W-1:0]         waddr, raddr;
  logic [VALUE_W-1:0]        wdata, rdata;

  logic                      full, empty, pos_bad, hit, last, swap;
  logic [ADDR_W-1:0]         slot_cmp, slot_next, slot_prev, slot_end, front_dec;
  logic [ADDR_W-1:0]         slot_rdf, slot_rdb;
  logic [CNT_W-1:0]          back_off;
  logic [POS_W-1:0]          pos_m1;

  assign full      = (count_r == CNT_FULL);
  assign empty     = (count_r == '0);
  assign pos_bad   = (cmd_r.position == '0) || (cmd_r.position > count_r);
  assign hit       = (rdata == cmd_r.value);
  assign last      = ({1'b0, cmp_r} == (count_r - 1'b1));
  assign swap      = (cmp_r != '0) && tp_en;
  assign pos_m1    = cmd_r.position - 1'b1;
  assign back_off  = count_r - cmd_r.position;
  assign slot_cmp  = slot_add(front_r, cmp_r);
  assign slot_next = slot_add(front_r, cmp_r + 1'b1);
  assign slot_prev = slot_add(front_r, cmp_r - 1'b1);
  assign slot_end  = slot_add(front_r, count_r[ADDR_W-1:0]);
  assign slot_rdf  = slot_add(front_r, pos_m1[ADDR_W-1:0]);
  assign slot_rdb  = slot_add(front_r, back_off[ADDR_W-1:0]);
  assign front_dec = (front_r == '0) ? SLOT_TOP : front_r - 1'b1;

  // store port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = slot_end;
    wdata = cmd_r.value;
    raddr = slot_next;
    unique case (state_r)
      S_DISPATCH: begin
        case (cmd_r.kind)
          KIND_APPEND_END: begin
            we = !full;
          end
          KIND_APPEND_FRONT: begin
            we    = !full;
            waddr = front_dec;
          end
          KIND_SEARCH: begin
            re    = !empty;
            raddr = front_r;
          end
          KIND_READ_FRONT: begin
            re    = !pos_bad;
            raddr = slot_rdf;
          end
          KIND_READ_BACK: begin
            re    = !pos_bad;
            raddr = slot_rdb;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (hit) begin
          we    = swap;
          waddr = slot_prev;
        end else begin
          re = !last;
        end
      end
      S_SWAP: begin
        we    = 1'b1;
        waddr = slot_cmp;
        wdata = prev_r;
      end
      default: ;
    endcase
  end

  solt_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          status_r <= ST_OK;
          index_r  <= '0;
          rdval_r  <= '0;
          cmp_r    <= '0;
          state_r  <= S_DONE;
          case (cmd_r.kind) inside
            KIND_APPEND_END, KIND_APPEND_FRONT: begin
              if (full) begin
                status_r <= ST_FULL;
              end else begin
                count_r <= count_r + 1'b1;
                if (cmd_r.kind == KIND_APPEND_FRONT) begin
                  front_r <= front_dec;
                end
              end
            end
            KIND_DELETE_FRONT: begin
              if (empty) begin
                status_r <= ST_EMPTY;
              end else begin
                front_r <= slot_add(front_r, ADDR_W'(1));
                count_r <= count_r - 1'b1;
              end
            end
            KIND_SEARCH: begin
              if (empty) begin
                status_r <= ST_NOT_FOUND;
              end else begin
                state_r <= S_SCAN;
              end
            end
            KIND_READ_FRONT, KIND_READ_BACK: begin
              if (empty && cmd_r.kind == KIND_READ_BACK) begin
                status_r <= ST_EMPTY;
              end else if (pos_bad) begin
                status_r <= ST_NOT_FOUND;
              end else begin
                state_r <= S_RDWAIT;
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (hit) begin
            index_r <= swap ? cmp_r - 1'b1 : cmp_r;
            state_r <= swap ? S_SWAP : S_DONE;
          end else begin
            prev_r <= rdata;
            cmp_r  <= cmp_r + 1'b1;
            if (last) begin
              status_r <= ST_NOT_FOUND;
              state_r  <= S_DONE;
            end
          end
        end
        S_SWAP: begin
          state_r <= S_DONE;
        end
        S_RDWAIT: begin
          rdval_r <= rdata;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = '{status: status_r, index: index_r, read_value: rdval_r,
                       length: count_r};

  `SOLT_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_FULL, "entry count above capacity")
  `SOLT_ASSERT_NXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "second command taken")
  `SOLT_ASSERT_IMP(a_scan_in_list, state_r == S_SCAN, ({1'b0, cmp_r} < count_r), "scan past list end")
  `SOLT_ASSERT_IMP(a_full_status, res_valid && res.status == ST_FULL, full, "full flagged on short list")

endmodule

// ----- rtl/self_organizing_list_transpose.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// self_organizing_list_transpose
// Self-organising list (transpose heuristic) in a 1024-entry ring store.
// ---------------------------------------------------------------------------
// One command in, one result out. The list lives in a single-port-per-side
// RAM addressed from a front pointer, so commands are worked one at a time:
// appends, delete, unknown kinds and out-of-range reads pass the engine
// through accept, execute and hand-over to the output register; a valid read
// adds a wait for the RAM read. A search walks the list through the RAM
// read port one entry a cycle, examining up to the list length (1024 entries
// worst case), and adds a swap step when a hit is swapped one place forward.
// The result sits in an output register, so the next command is taken while
// a result waits to be collected. No clearing pass after reset: only slots
// that hold list entries are ever read.
// ---------------------------------------------------------------------------
module self_organizing_list_transpose (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] value, [42:32] position, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [9:0] index, [41:10] read_value,
                                  // [52:42] length, rest zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import solt_pkg::*;

  cmd_t cmd;
  res_t eng_res;
  res_t out_res_r;
  logic eng_valid, eng_ready;
  logic out_valid_r;
  logic tp_en_r;

  // register block: single bit, transpose enable, resets to on
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TRANSPOSE_EN) ? {31'b0, tp_en_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_en_r <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TRANSPOSE_EN) begin
      tp_en_r <= pwdata[0];
    end
  end

  // unpack command transfer
  assign cmd.kind     = in_tuser;
  assign cmd.value    = in_tdata[31:0];
  assign cmd.position = in_tdata[42:32];

  solt_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(in_tvalid),
    .cmd_ready(in_tready),
    .cmd      (cmd),
    .tp_en    (tp_en_r),
    .res_valid(eng_valid),
    .res_ready(eng_ready),
    .res      (eng_res)
  );

  // output register: takes the engine's result whenever it is empty or
  // being drained this cycle
  assign eng_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (eng_valid && eng_ready) begin
        out_valid_r <= 1'b1;
        out_res_r   <= eng_res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {3'b0, out_res_r.length, out_res_r.read_value, out_res_r.index};

endmodule

// ----- bench/tb_self_organizing_list_transpose.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_self_organizing_list_transpose
// Self-checking bench for the transpose-heuristic self-organising list.
// ---------------------------------------------------------------------------
// Commands go in on the in_ stream and results come back on the out_ stream.
// Every accepted command is run through a behavioural copy of the list, which
// queues the result it should produce. Each returned transfer is checked field
// by field against the oldest queued result.
// The run has five phases:
//   - a directed table covering the empty list, the extremes and each kind
//   - random traffic with transpose on
//   - random traffic with transpose off
//   - grow a long list, reads past its end, searches that walk all of it,
//     then shrink it again
//   - random traffic with transpose on again
// Both stream sides idle at random. The receiver holds off once for a long
// stretch so that the block backs up. The register is written only once the
// block has gone quiet.
// ---------------------------------------------------------------------------
module tb_self_organizing_list_transpose;
  import solt_pkg::*;

  // kinds the block ignores, not named in the package
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  localparam logic [2:0] TRANSPOSE_ADDR = {REG_TRANSPOSE_EN, 2'b00};

  // covers the worst search, the long hold-off and the longest gaps
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 40;
  // list length reached in the long-list phase
  localparam int DEEP_LEN       = 96;

  typedef struct packed {
    cmd_t cmd;
    logic typed;   // 1: use the typed-in result, not the predictor's
    res_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // [31:0] value, [42:32] position, rest zero
  logic [2:0]  in_tuser = '0;   // [2:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // [9:0] index, [41:10] read_value, [52:42] length
  logic [1:0]  out_tuser;       // [1:0] status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  self_organizing_list_transpose i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Behavioural list: ring of CAPACITY slots, head slot and entry count
  // -------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] list_slots [CAPACITY];
  int   list_head = 0;
  int   list_len  = 0;
  logic swap_on   = 1'b1;   // register reset value

  res_t pending_results [$];

  int fail_count      = 0;
  int results_checked = 0;
  int issued          = 0;
  int deepest         = 0;
  int len_target      = 8;
  bit send_calm       = 1'b0;
  int kind_seen   [8];
  int status_seen [4];

  // Apply one command to the behavioural list, return the result it gives.
  function automatic res_t list_apply(input cmd_t c);
    res_t r;
    bit   hit;
    int   k;
    int   s;
    int   p;
    logic signed [VALUE_W-1:0] t;
    r   = '0;
    hit = 1'b0;
    case (c.kind)
      KIND_APPEND_END: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_slots[(list_head + list_len) % CAPACITY] = c.value;
          list_len++;
        end
      end
      KIND_APPEND_FRONT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_head = (list_head + CAPACITY - 1) % CAPACITY;
          list_slots[list_head] = c.value;
          list_len++;
        end
      end
      KIND_DELETE_FRONT: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          list_head = (list_head + 1) % CAPACITY;
          list_len--;
        end
      end
      KIND_SEARCH: begin
        r.status = ST_NOT_FOUND;
        // first hit wins; with transpose on it trades places with its predecessor
        for (k = 0; k < list_len && !hit; k++) begin
          s = (list_head + k) % CAPACITY;
          if (list_slots[s] == c.value) begin
            hit      = 1'b1;
            r.status = ST_OK;
            r.index  = INDEX_W'(k);
            if (k > 0 && swap_on) begin
              p             = (list_head + k - 1) % CAPACITY;
              t             = list_slots[p];
              list_slots[p] = list_slots[s];
              list_slots[s] = t;
              r.index       = INDEX_W'(k - 1);
            end
          end
        end
      end
      KIND_READ_FRONT: begin
        if (c.position == 0 || c.position > list_len) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.read_value = list_slots[(list_head + c.position - 1) % CAPACITY];
        end
      end
      KIND_READ_BACK: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (c.position == 0 || c.position > list_len) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.read_value = list_slots[(list_head + list_len - c.position) % CAPACITY];
        end
      end
      default: ;   // spare kinds leave the list alone
    endcase
    r.length = CNT_W'(list_len);
    return r;
  endfunction

  function automatic plan_row_t mk_row(input logic [KIND_W-1:0] kind,
                                       input logic signed [VALUE_W-1:0] value,
                                       input logic [POS_W-1:0] position,
                                       input logic typed,
                                       input logic [STATUS_W-1:0] status,
                                       input logic [INDEX_W-1:0] index,
                                       input logic signed [VALUE_W-1:0] read_value,
                                       input logic [CNT_W-1:0] length);
    plan_row_t row;
    row.cmd.kind        = kind;
    row.cmd.value       = value;
    row.cmd.position    = position;
    row.typed           = typed;
    row.want.status     = status;
    row.want.index      = index;
    row.want.read_value = read_value;
    row.want.length     = length;
    return row;
  endfunction

  // value picked so that duplicates and the extremes turn up often
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Random command, steered so the list length wanders toward len_target.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    pick       = $urandom_range(0, 99);
    c.value    = $urandom();
    c.position = POS_W'($urandom_range(0, 2047));
    if (pick < 3)       c.kind = (pick == 0) ? KIND_SPARE_A : KIND_SPARE_B;
    else if (pick < 25) c.kind = KIND_APPEND_END;
    else if (pick < 37) c.kind = KIND_APPEND_FRONT;
    else if (pick < 50) c.kind = KIND_DELETE_FRONT;
    else if (pick < 78) c.kind = KIND_SEARCH;
    else if (pick < 89) c.kind = KIND_READ_FRONT;
    else                c.kind = KIND_READ_BACK;

    if (list_len > len_target && (c.kind == KIND_APPEND_END ||
        c.kind == KIND_APPEND_FRONT) && $urandom_range(0, 2) != 0) begin
      c.kind = KIND_DELETE_FRONT;
    end else if (list_len < len_target && c.kind == KIND_DELETE_FRONT) begin
      c.kind = KIND_APPEND_END;
    end

    case (c.kind) inside
      KIND_APPEND_END, KIND_APPEND_FRONT: c.value = pick_value();
      KIND_SEARCH: begin
        // mostly search for something that is there
        if (list_len > 0 && $urandom_range(0, 3) != 0) begin
          c.value = list_slots[(list_head + $urandom_range(0, list_len - 1)) % CAPACITY];
        end else begin
          c.value = pick_value();
        end
      end
      KIND_READ_FRONT, KIND_READ_BACK: begin
        pick = $urandom_range(0, 9);
        if (pick < 8 && list_len > 0) begin
          c.position = POS_W'($urandom_range(1, list_len));
        end else if (pick < 9) begin
          c.position = ($urandom_range(0, 1) == 0) ? POS_W'(0) : POS_W'(list_len + 1);
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  // Sender gap after a transfer. Zero keeps tvalid up for the next command.
  task automatic sender_gap();
    int n;
    int r;
    n = 0;
    if (!send_calm) begin
      r = $urandom_range(0, 19);
      if (r >= 19)      n = $urandom_range(20, 60);
      else if (r >= 18) n = $urandom_range(4, 10);
      else if (r >= 12) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one command, wait for the transfer, queue its expected result.
  task automatic issue(input cmd_t c, input logic typed, input res_t typed_want);
    res_t predicted;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, c.position, c.value};
    in_tuser  <= c.kind;
    do @(posedge clk); while (!in_tready);
    predicted = list_apply(c);
    pending_results = {pending_results, typed ? typed_want : predicted};
    kind_seen[c.kind]++;
    if (list_len > deepest) deepest = list_len;
    issued++;
    if (issued % 32 == 0) send_calm = ($urandom_range(0, 3) == 0);
    sender_gap();
  endtask

  task automatic send(input cmd_t c);
    issue(c, 1'b0, '0);
  endtask

  // Sender stops and waits until every queued result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write followed by a read-back; only called with the block idle.
  task automatic set_transpose(input logic on);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TRANSPOSE_ADDR;
    pwdata  <= {31'b0, on};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    swap_on = on;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, on}) begin
      $error("transpose_enable read-back: expected %0d, got 0x%08h", on, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_run(input int n_items);
    cmd_t c;
    int   counted;
    counted = 0;
    while (counted < n_items) begin
      if (counted % 40 == 0) begin
        len_target = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                 : $urandom_range(8, 60);
      end
      c = random_cmd();
      send(c);
      // spare kinds are ignored by the block and do not count
      if (c.kind <= KIND_READ_BACK) counted++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Result side: random tready, one long hold-off, field-by-field check
  // -------------------------------------------------------------------------
  task automatic check_result();
    res_t want;
    logic [INDEX_W-1:0]        got_index;
    logic signed [VALUE_W-1:0] got_value;
    logic [CNT_W-1:0]          got_length;
    got_index  = out_tdata[9:0];
    got_value  = out_tdata[41:10];
    got_length = out_tdata[52:42];
    if (pending_results.size() == 0) begin
      $error("unexpected result transfer: status %0d index %0d read_value %0d length %0d",
             out_tuser, got_index, got_value, got_length);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      results_checked++;
      status_seen[want.status]++;
      if (out_tuser !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_tuser);
        fail_count++;
      end
      if (got_index !== want.index) begin
        $error("index: expected %0d, got %0d", want.index, got_index);
        fail_count++;
      end
      if (got_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got_value);
        fail_count++;
      end
      if (got_length !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, got_length);
        fail_count++;
      end
    end
  endtask

  initial begin : result_sink
    int  stall;
    int  tick;
    int  r;
    bit  held;
    bit  recv_calm;
    stall     = 0;
    tick      = 0;
    held      = 1'b0;
    recv_calm = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) check_result();
      tick++;
      if (tick % 100 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      if (!held && results_checked >= 60) begin
        // long hold-off: the sender keeps offering, so the block backs up
        held  = 1'b1;
        stall = 300;
      end else if (stall == 0 && !recv_calm) begin
        r = $urandom_range(0, 19);
        if (r >= 19)      stall = $urandom_range(20, 60);
        else if (r >= 18) stall = $urandom_range(4, 12);
        else if (r >= 14) stall = $urandom_range(1, 3);
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Ends the run when nothing has moved on either stream for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $error("no transfer for %0d cycles, %0d results outstanding",
           WATCHDOG_LIMIT, pending_results.size());
    $display("self_organizing_list_transpose regression: fail");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t plan_q [$];
    cmd_t      c;
    int        k;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, transpose at its reset value (on)
    plan_q = {plan_q, mk_row(KIND_DELETE_FRONT, 0, 0, 1, ST_EMPTY, 0, 0, 0)};
    plan_q = {plan_q, mk_row(KIND_READ_BACK, 0, 1, 1, ST_EMPTY, 0, 0, 0)};
    plan_q = {plan_q, mk_row(KIND_READ_FRONT, 0, 1, 1, ST_NOT_FOUND, 0, 0, 0)};
    plan_q = {plan_q, mk_row(KIND_SEARCH, 5, 0, 1, ST_NOT_FOUND, 0, 0, 0)};
    plan_q = {plan_q, mk_row(KIND_APPEND_END, 32'sh7FFF_FFFF, 0, 1, ST_OK, 0, 0, 1)};
    plan_q = {plan_q, mk_row(KIND_APPEND_FRONT, 32'sh8000_0000, 0, 1, ST_OK, 0, 0, 2)};
    plan_q = {plan_q, mk_row(KIND_APPEND_END, -1, 0, 1, ST_OK, 0, 0, 3)};
    plan_q = {plan_q, mk_row(KIND_APPEND_END, 0, 0, 1, ST_OK, 0, 0, 4)};
    // list now: min, max, -1, 0
    plan_q = {plan_q, mk_row(KIND_READ_FRONT, 0, 0, 1, ST_NOT_FOUND, 0, 0, 4)};
    plan_q = {plan_q, mk_row(KIND_READ_FRONT, 0, 5, 1, ST_NOT_FOUND, 0, 0, 4)};
    plan_q = {plan_q, mk_row(KIND_READ_FRONT, 0, 2047, 1, ST_NOT_FOUND, 0, 0, 4)};
    plan_q = {plan_q, mk_row(KIND_READ_FRONT, 0, 1, 1, ST_OK, 0, 32'sh8000_0000, 4)};
    plan_q = {plan_q, mk_row(KIND_READ_BACK, 0, 1, 1, ST_OK, 0, 0, 4)};
    plan_q = {plan_q, mk_row(KIND_READ_BACK, 0, 4, 1, ST_OK, 0, 32'sh8000_0000, 4)};
    plan_q = {plan_q, mk_row(KIND_READ_BACK, 0, 0, 1, ST_NOT_FOUND, 0, 0, 4)};
    // hit at the head: no swap
    plan_q = {plan_q, mk_row(KIND_SEARCH, 32'sh8000_0000, 0, 1, ST_OK, 0, 0, 4)};
    // hit at the tail: swaps forward, reports one less
    plan_q = {plan_q, mk_row(KIND_SEARCH, 0, 0, 1, ST_OK, 2, 0, 4)};
    plan_q = {plan_q, mk_row(KIND_SEARCH, 12345, 0, 1, ST_NOT_FOUND, 0, 0, 4)};
    plan_q = {plan_q, mk_row(KIND_SPARE_A, 32'h5555_5555, 11'h2AA, 1, ST_OK, 0, 0, 4)};
    plan_q = {plan_q, mk_row(KIND_SPARE_B, 32'hAAAA_AAAA, 11'h555, 1, ST_OK, 0, 0, 4)};
    plan_q = {plan_q, mk_row(KIND_SEARCH, -1, 0, 0, 0, 0, 0, 0)};
    plan_q = {plan_q, mk_row(KIND_READ_FRONT, 0, 3, 0, 0, 0, 0, 0)};
    plan_q = {plan_q, mk_row(KIND_DELETE_FRONT, 0, 0, 0, 0, 0, 0, 0)};
    plan_q = {plan_q, mk_row(KIND_READ_BACK, 0, 3, 0, 0, 0, 0, 0)};
    plan_q = {plan_q, mk_row(KIND_APPEND_FRONT, 1, 0, 0, 0, 0, 0, 0)};
    foreach (plan_q[k]) issue(plan_q[k].cmd, plan_q[k].typed, plan_q[k].want);

    random_run(150);

    drain();
    set_transpose(1'b0);
    random_run(120);

    // grow a long list with transpose on
    drain();
    set_transpose(1'b1);
    while (list_len < DEEP_LEN) begin
      c.kind     = ($urandom_range(0, 3) == 0) ? KIND_APPEND_FRONT : KIND_APPEND_END;
      c.value    = $urandom();
      c.position = POS_W'($urandom_range(0, 2047));
      send(c);
    end
    c.value    = $urandom();
    c.kind     = KIND_READ_FRONT;
    c.position = POS_W'(list_len);   send(c);
    c.kind     = KIND_READ_BACK;     send(c);
    c.position = POS_W'(CAPACITY);   send(c);
    c.kind     = KIND_READ_FRONT;    send(c);
    // last entry found after a full walk, swapped to the one before
    c.kind     = KIND_SEARCH;
    c.value    = list_slots[(list_head + list_len - 1) % CAPACITY];
    send(c);
    c.kind     = KIND_READ_BACK;
    c.position = 1;
    send(c);

    // same walk with transpose off reports the last index itself
    drain();
    set_transpose(1'b0);
    c.kind  = KIND_SEARCH;
    c.value = list_slots[(list_head + list_len - 1) % CAPACITY];
    send(c);
    c.value = $urandom();
    send(c);

    // shrink back down to 12 entries, reads sprinkled in
    k = 0;
    while (list_len > 12) begin
      k++;
      c.value    = $urandom();
      c.position = POS_W'($urandom_range(1, list_len));
      c.kind     = (k % 50 == 0) ? KIND_READ_FRONT : KIND_DELETE_FRONT;
      send(c);
    end

    drain();
    set_transpose(1'b1);
    random_run(120);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d commands (append end %0d, front %0d, delete %0d, search %0d,",
             issued, kind_seen[KIND_APPEND_END], kind_seen[KIND_APPEND_FRONT],
             kind_seen[KIND_DELETE_FRONT], kind_seen[KIND_SEARCH]);
    $display("  reads %0d, spare %0d); %0d results, full %0d, empty %0d, miss %0d, depth %0d",
             kind_seen[KIND_READ_FRONT] + kind_seen[KIND_READ_BACK],
             kind_seen[KIND_SPARE_A] + kind_seen[KIND_SPARE_B], results_checked,
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND],
             deepest);
    if (fail_count == 0) begin
      $display("self_organizing_list_transpose regression: pass");
    end else begin
      $display("self_organizing_list_transpose regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/solt_pkg.sv
rtl/solt_ram.sv
rtl/solt_engine.sv
rtl/self_organizing_list_transpose.sv
bench/tb_self_organizing_list_transpose.sv
